/* hw/rtl/svmix_pkg.sv */
package svmix_pkg;

	localparam int PulseW   = 12;
	localparam int NumServo = 6;
	localparam int PerReg   = 3;
	localparam int RegW     = PerReg * PulseW;
	localparam int CmdW     = 12;
	localparam int RollW    = 15;
	localparam int QuotW    = 9;
	localparam int FifthW   = 10;
	localparam int GyroW    = 13;
	localparam int SumW     = 16;
	localparam int CntW     = 3;
	localparam int DiffW    = 4;
	localparam int ModeW    = 3;
	localparam int SetupW   = ModeW + DiffW + NumServo;
	localparam int IdxW     = 3;

	localparam int GyroCenter = 1500;
	localparam int QuadIdle   = 100;

	typedef logic [PulseW-1:0] pulse_t;

	localparam pulse_t NEUTRAL_RST = pulse_t'(1500);
	localparam pulse_t MINIMUM_RST = pulse_t'(1000);
	localparam pulse_t MAXIMUM_RST = pulse_t'(2000);

	typedef enum logic [ModeW-1:0] {
		MODE_AILERON     = 3'd0,
		MODE_DELTA_PLUS  = 3'd1,
		MODE_DELTA_MINUS = 3'd2,
		MODE_QUAD        = 3'd3,
		MODE_FLAPERON    = 3'd4
	} mix_mode_t;

	localparam logic [IdxW-1:0] REG_MIXING_SETUP = 3'd0;
	localparam logic [IdxW-1:0] REG_NEUTRAL_LOW  = 3'd1;
	localparam logic [IdxW-1:0] REG_NEUTRAL_HIGH = 3'd2;
	localparam logic [IdxW-1:0] REG_MINIMUM_LOW  = 3'd3;
	localparam logic [IdxW-1:0] REG_MINIMUM_HIGH = 3'd4;
	localparam logic [IdxW-1:0] REG_MAXIMUM_LOW  = 3'd5;
	localparam logic [IdxW-1:0] REG_MAXIMUM_HIGH = 3'd6;

	localparam logic [CntW-1:0] CNT_QUAD  = 3'd4;
	localparam logic [CntW-1:0] CNT_DELTA = 3'd5;
	localparam logic [CntW-1:0] CNT_WING  = 3'd6;

	typedef struct packed {
		logic [ModeW-1:0]                mode;
		logic [DiffW-1:0]                diff;
		logic [NumServo-1:0]             rev;
		pulse_t [NumServo-1:0]           neutral;
		pulse_t [NumServo-1:0]           minimum;
		pulse_t [NumServo-1:0]           maximum;
	} mix_cfg_t;

	typedef struct packed {
		logic signed [CmdW-1:0]   aileron;
		logic signed [CmdW-1:0]   elevator;
		logic signed [CmdW-1:0]   motor;
		logic signed [CmdW-1:0]   yaw;
		logic signed [CmdW-1:0]   rudder;
		logic signed [QuotW-1:0]  ail_tenth;
		logic signed [FifthW-1:0] ail_fifth;
		logic signed [FifthW-1:0] elev_fifth;
		logic signed [FifthW-1:0] yaw_fifth;
		logic signed [GyroW-1:0]  gyro;
	} mix_item_t;

endpackage

/* hw/rtl/servo_output_mixer.sv */
// Servo output mixer.
// Input channel: in_valid / in_stall with one set of aileron, elevator, motor,
// yaw, rudder stick offset and roll angle per transaction. Output channel:
// out_valid / out_stall with six stored servo pulses and the count of
// channels that the transaction drove; undriven servos repeat their old value.
// Configuration: a write with cfg_we high at a clock edge stores cfg_wdata into
// the register at cfg_index; write only while no transaction is in flight.
// Throughput: one transaction per cycle while the result is not stalled; the
// input register feeds the mixer and clamp combinationally into the result
// register, and the stored pulses are the result register, so each transaction
// sees the pulses the previous one left.
// When the receiver stalls, the result holds and the input register fills;
// in_stall rises once both are occupied and the result is still stalled.
// Reset: both registers empty, stored pulses zero, mode aileron, neutrals
// 1500, minimums 1000, maximums 2000.
module servo_output_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [svmix_pkg::IdxW-1:0]         cfg_index,
	input  logic [svmix_pkg::RegW-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [svmix_pkg::CmdW-1:0]  aileron_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  elevator_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  motor_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  yaw_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  rudder_stick_offset,
	input  logic signed [svmix_pkg::RollW-1:0] roll_angle,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [svmix_pkg::PulseW-1:0]       pulse_zero,
	output logic [svmix_pkg::PulseW-1:0]       pulse_one,
	output logic [svmix_pkg::PulseW-1:0]       pulse_two,
	output logic [svmix_pkg::PulseW-1:0]       pulse_three,
	output logic [svmix_pkg::PulseW-1:0]       pulse_four,
	output logic [svmix_pkg::PulseW-1:0]       pulse_five,
	output logic [svmix_pkg::CntW-1:0]         channels_driven
);

	svmix_pkg::mix_cfg_t                         cfg;
	svmix_pkg::mix_item_t                        item_s1;
	svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] held;
	svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] next_held;
	logic [svmix_pkg::CntW-1:0]                  next_cnt;
	logic                                        valid_s1;
	logic                                        advance;
	logic                                        load;

	assign advance  = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	svmix_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	svmix_in_stage u_in (
		.clk                 (clk),
		.arst_n              (arst_n),
		.load                (load),
		.advance             (advance),
		.aileron_cmd         (aileron_cmd),
		.elevator_cmd        (elevator_cmd),
		.motor_cmd           (motor_cmd),
		.yaw_cmd             (yaw_cmd),
		.rudder_stick_offset (rudder_stick_offset),
		.roll_angle          (roll_angle),
		.valid_s1            (valid_s1),
		.item_s1             (item_s1)
	);

	svmix_mix u_mix (
		.item      (item_s1),
		.cfg       (cfg),
		.held      (held),
		.next_held (next_held),
		.cnt       (next_cnt)
	);

	svmix_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.out_stall (out_stall),
		.next_held (next_held),
		.next_cnt  (next_cnt),
		.out_valid (out_valid),
		.held      (held),
		.cnt       (channels_driven)
	);

	assign pulse_zero  = held[0];
	assign pulse_one   = held[1];
	assign pulse_two   = held[2];
	assign pulse_three = held[3];
	assign pulse_four  = held[4];
	assign pulse_five  = held[5];

endmodule

/* hw/rtl/svmix_cfg.sv */
module svmix_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [svmix_pkg::IdxW-1:0]       cfg_index,
	input  logic [svmix_pkg::RegW-1:0]       cfg_wdata,
	output svmix_pkg::mix_cfg_t              cfg
);

	logic [svmix_pkg::SetupW-1:0]                      setup_q;
	svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0]       neutral_q;
	svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0]       minimum_q;
	svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0]       maximum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q   <= '0;
			neutral_q <= {svmix_pkg::NumServo{svmix_pkg::NEUTRAL_RST}};
			minimum_q <= {svmix_pkg::NumServo{svmix_pkg::MINIMUM_RST}};
			maximum_q <= {svmix_pkg::NumServo{svmix_pkg::MAXIMUM_RST}};
		end else if (cfg_we) begin
			case (cfg_index)
				svmix_pkg::REG_MIXING_SETUP: begin
					setup_q <= cfg_wdata[svmix_pkg::SetupW-1:0];
				end
				svmix_pkg::REG_NEUTRAL_LOW: begin
					for (int k = 0; k < svmix_pkg::PerReg; k++)
						neutral_q[k] <= cfg_wdata[k*svmix_pkg::PulseW +: svmix_pkg::PulseW];
				end
				svmix_pkg::REG_NEUTRAL_HIGH: begin
					for (int k = 0; k < svmix_pkg::PerReg; k++)
						neutral_q[k+svmix_pkg::PerReg] <=
							cfg_wdata[k*svmix_pkg::PulseW +: svmix_pkg::PulseW];
				end
				svmix_pkg::REG_MINIMUM_LOW: begin
					for (int k = 0; k < svmix_pkg::PerReg; k++)
						minimum_q[k] <= cfg_wdata[k*svmix_pkg::PulseW +: svmix_pkg::PulseW];
				end
				svmix_pkg::REG_MINIMUM_HIGH: begin
					for (int k = 0; k < svmix_pkg::PerReg; k++)
						minimum_q[k+svmix_pkg::PerReg] <=
							cfg_wdata[k*svmix_pkg::PulseW +: svmix_pkg::PulseW];
				end
				svmix_pkg::REG_MAXIMUM_LOW: begin
					for (int k = 0; k < svmix_pkg::PerReg; k++)
						maximum_q[k] <= cfg_wdata[k*svmix_pkg::PulseW +: svmix_pkg::PulseW];
				end
				svmix_pkg::REG_MAXIMUM_HIGH: begin
					for (int k = 0; k < svmix_pkg::PerReg; k++)
						maximum_q[k+svmix_pkg::PerReg] <=
							cfg_wdata[k*svmix_pkg::PulseW +: svmix_pkg::PulseW];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.mode    = setup_q[svmix_pkg::ModeW-1:0];
	assign cfg.diff    = setup_q[svmix_pkg::ModeW +: svmix_pkg::DiffW];
	assign cfg.rev     = setup_q[svmix_pkg::ModeW+svmix_pkg::DiffW +: svmix_pkg::NumServo];
	assign cfg.neutral = neutral_q;
	assign cfg.minimum = minimum_q;
	assign cfg.maximum = maximum_q;

endmodule

/* hw/rtl/svmix_in_stage.sv */
module svmix_in_stage (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic                               advance,
	input  logic signed [svmix_pkg::CmdW-1:0]  aileron_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  elevator_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  motor_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  yaw_cmd,
	input  logic signed [svmix_pkg::CmdW-1:0]  rudder_stick_offset,
	input  logic signed [svmix_pkg::RollW-1:0] roll_angle,
	output logic                               valid_s1,
	output svmix_pkg::mix_item_t               item_s1
);

	localparam int ProdW      = 25;
	localparam int RecipShift = 16;
	// ceil(2^16/10) and ceil(2^16/5): exact truncation for 12-bit magnitudes
	localparam logic [ProdW-1:0] RecipTen  = 25'd6554;
	localparam logic [ProdW-1:0] RecipFive = 25'd13108;
	localparam logic [ProdW-1:0] GyroGain  = 25'd636;
	localparam int GyroShift = 12;
	localparam int GyroMagW  = svmix_pkg::GyroW - 1;

	svmix_pkg::mix_item_t item_d;

	function automatic logic signed [svmix_pkg::QuotW-1:0] div_ten(
		logic signed [svmix_pkg::CmdW-1:0] x);
		logic [svmix_pkg::CmdW-1:0]    mag;
		logic [ProdW-1:0]              prod;
		logic [svmix_pkg::QuotW-1:0]   quo;
		mag  = x[svmix_pkg::CmdW-1] ? svmix_pkg::CmdW'(-x) : x;
		prod = ProdW'(mag) * RecipTen;
		quo  = {1'b0, prod[RecipShift +: svmix_pkg::QuotW-1]};
		return x[svmix_pkg::CmdW-1] ? svmix_pkg::QuotW'(0) - quo : quo;
	endfunction

	function automatic logic signed [svmix_pkg::FifthW-1:0] div_five(
		logic signed [svmix_pkg::CmdW-1:0] x);
		logic [svmix_pkg::CmdW-1:0]    mag;
		logic [ProdW-1:0]              prod;
		logic [svmix_pkg::FifthW-1:0]  quo;
		mag  = x[svmix_pkg::CmdW-1] ? svmix_pkg::CmdW'(-x) : x;
		prod = ProdW'(mag) * RecipFive;
		quo  = {1'b0, prod[RecipShift +: svmix_pkg::FifthW-1]};
		return x[svmix_pkg::CmdW-1] ? svmix_pkg::FifthW'(0) - quo : quo;
	endfunction

	function automatic logic signed [svmix_pkg::GyroW-1:0] gyro_of(
		logic signed [svmix_pkg::RollW-1:0] x);
		logic [svmix_pkg::RollW-1:0]   mag;
		logic [ProdW-1:0]              prod;
		logic [svmix_pkg::GyroW-1:0]   g;
		mag  = x[svmix_pkg::RollW-1] ? svmix_pkg::RollW'(-x) : x;
		prod = ProdW'(mag) * GyroGain;
		g    = {1'b0, prod[GyroShift +: GyroMagW]};
		return x[svmix_pkg::RollW-1] ? svmix_pkg::GyroW'(0) - g : g;
	endfunction

	always_comb begin
		item_d.aileron    = aileron_cmd;
		item_d.elevator   = elevator_cmd;
		item_d.motor      = motor_cmd;
		item_d.yaw        = yaw_cmd;
		item_d.rudder     = rudder_stick_offset;
		item_d.ail_tenth  = div_ten(aileron_cmd);
		item_d.ail_fifth  = div_five(aileron_cmd);
		item_d.elev_fifth = div_five(elevator_cmd);
		item_d.yaw_fifth  = div_five(yaw_cmd);
		item_d.gyro       = gyro_of(roll_angle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_d;
		end
	end

endmodule

/* hw/rtl/svmix_mix.sv */
module svmix_mix (
	input  svmix_pkg::mix_item_t                        item,
	input  svmix_pkg::mix_cfg_t                         cfg,
	input  svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] held,
	output svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] next_held,
	output logic [svmix_pkg::CntW-1:0]                  cnt
);

	localparam int W = svmix_pkg::SumW;

	always_comb begin
		logic signed [W-1:0] a, e, m, w, y, q, qd, r, l, yy, g, a5, e5, w5, ctr;
		logic signed [W-1:0] x, mx, mn;
		logic signed [W-1:0] v [svmix_pkg::NumServo];
		logic signed [W-1:0] n [svmix_pkg::NumServo];

		a   = W'($signed(item.aileron));
		e   = W'($signed(item.elevator));
		m   = W'($signed(item.motor));
		w   = W'($signed(item.yaw));
		y   = W'($signed(item.rudder));
		q   = W'($signed(item.ail_tenth));
		a5  = W'($signed(item.ail_fifth));
		e5  = W'($signed(item.elev_fifth));
		w5  = W'($signed(item.yaw_fifth));
		g   = W'($signed(item.gyro));
		ctr = W'(svmix_pkg::GyroCenter);
		qd  = q * $signed(W'(cfg.diff));

		if (!a[W-1] && (a != '0)) begin
			r = a + qd;
			l = a - qd;
		end else begin
			r = a - qd;
			l = a + qd;
		end

		for (int i = 0; i < svmix_pkg::NumServo; i++) begin
			n[i] = $signed(W'(cfg.neutral[i]));
			v[i] = $signed(W'(held[i]));
		end

		yy  = '0;
		cnt = svmix_pkg::CNT_WING;
		case (cfg.mode)
			svmix_pkg::MODE_DELTA_PLUS, svmix_pkg::MODE_DELTA_MINUS: begin
				cnt  = svmix_pkg::CNT_DELTA;
				v[4] = cfg.rev[4] ? ctr - g : ctr + g;
				if (cfg.mode == svmix_pkg::MODE_DELTA_PLUS) begin
					v[0] = (cfg.rev[0] ? (r + e) : (-r - e)) + n[0];
					v[1] = (cfg.rev[1] ? (l - e) : (-l + e)) + n[1];
				end else begin
					v[0] = (cfg.rev[0] ? (r - e) : (-r + e)) + n[0];
					v[1] = (cfg.rev[1] ? (l + e) : (-l - e)) + n[1];
				end
				v[3] = (cfg.rev[3] ? -m : m) + n[3];
			end
			svmix_pkg::MODE_QUAD: begin
				cnt  = svmix_pkg::CNT_QUAD;
				v[0] = m + a5 + w5 + n[0];
				v[1] = m + e5 - w5 + n[1];
				v[2] = m - a5 + w5 + n[2];
				v[3] = m - e5 - w5 + n[3];
				if (m < svmix_pkg::QuadIdle) begin
					for (int i = 0; i < 4; i++)
						v[i] = '0;
				end
			end
			default: begin
				if (cfg.mode == svmix_pkg::MODE_FLAPERON)
					yy = y;
				v[5] = cfg.rev[5] ? ctr - g : ctr + g;
				v[0] = (cfg.rev[0] ? (-r + yy) : (r - yy)) + n[0];
				v[1] = (cfg.rev[1] ? (l + yy) : (-l - yy)) + n[1];
				v[2] = (cfg.rev[2] ? -e : e) + n[2];
				v[3] = (cfg.rev[3] ? -m : m) + n[3];
				v[4] = (cfg.rev[4] ? w : -w) + n[4];
			end
		endcase

		for (int i = 0; i < svmix_pkg::NumServo; i++) begin
			x  = v[i];
			mx = $signed(W'(cfg.maximum[i]));
			mn = $signed(W'(cfg.minimum[i]));
			if (x > mx)
				x = mx;
			if (x < mn)
				x = mn;
			if (svmix_pkg::CntW'(i) < cnt)
				next_held[i] = x[svmix_pkg::PulseW-1:0];
			else
				next_held[i] = held[i];
		end
	end

endmodule

/* hw/rtl/svmix_out_stage.sv */
module svmix_out_stage (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        advance,
	input  logic                                        out_stall,
	input  svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] next_held,
	input  logic [svmix_pkg::CntW-1:0]                  next_cnt,
	output logic                                        out_valid,
	output svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] held,
	output logic [svmix_pkg::CntW-1:0]                  cnt
);

	logic                                        valid_q;
	svmix_pkg::pulse_t [svmix_pkg::NumServo-1:0] held_q;
	logic [svmix_pkg::CntW-1:0]                  cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			held_q  <= '0;
		end else begin
			if (advance) begin
				valid_q <= 1'b1;
				held_q  <= next_held;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			cnt_q <= next_cnt;
		end
	end

	assign out_valid = valid_q;
	assign held      = held_q;
	assign cnt       = cnt_q;

endmodule

/* hw/rtl/svmix_checker.sv */
module svmix_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [svmix_pkg::PulseW-1:0] pulse_zero,
	input logic [svmix_pkg::PulseW-1:0] pulse_one,
	input logic [svmix_pkg::PulseW-1:0] pulse_two,
	input logic [svmix_pkg::PulseW-1:0] pulse_three,
	input logic [svmix_pkg::PulseW-1:0] pulse_four,
	input logic [svmix_pkg::PulseW-1:0] pulse_five,
	input logic [svmix_pkg::CntW-1:0]   channels_driven
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pulse_zero) && $stable(pulse_one) &&
			$stable(pulse_two) && $stable(pulse_three) && $stable(pulse_four) &&
			$stable(pulse_five) && $stable(channels_driven))
		else $error("stalled result changed");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channels_driven == svmix_pkg::CNT_QUAD ||
			channels_driven == svmix_pkg::CNT_DELTA ||
			channels_driven == svmix_pkg::CNT_WING)
		else $error("bad driven channel count");

	// an empty output fills with a transaction that went through the input register straight into the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without matching input transaction");

endmodule

bind servo_output_mixer svmix_checker u_svmix_checker (.*);

/* verif/tb_servo_output_mixer.sv */
`timescale 1ns / 1ps

module tb_servo_output_mixer;
	import svmix_pkg::*;

	localparam int GYRO_GAIN  = 636;
	localparam int GYRO_SCALE = 4096;
	localparam int DIFF_DIV   = 10;
	localparam int QUAD_DIV   = 5;
	localparam int LONG_HOLD  = 60;
	localparam int QUIET_LIMIT = 3000;

	typedef struct packed {
		logic signed [CmdW-1:0]  ail;
		logic signed [CmdW-1:0]  elev;
		logic signed [CmdW-1:0]  motor;
		logic signed [CmdW-1:0]  yaw;
		logic signed [CmdW-1:0]  rudder;
		logic signed [RollW-1:0] roll;
	} servo_cmd_t;

	typedef struct packed {
		logic [SetupW-1:0]      setup;
		pulse_t [NumServo-1:0]  neutral;
		pulse_t [NumServo-1:0]  minimum;
		pulse_t [NumServo-1:0]  maximum;
	} mixer_setting_t;

	typedef struct packed {
		pulse_t [NumServo-1:0] pulse;
		logic [CntW-1:0]       driven;
	} servo_frame_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [IdxW-1:0] cfg_index = '0;
	logic [RegW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CmdW-1:0] aileron_cmd = '0;
	logic signed [CmdW-1:0] elevator_cmd = '0;
	logic signed [CmdW-1:0] motor_cmd = '0;
	logic signed [CmdW-1:0] yaw_cmd = '0;
	logic signed [CmdW-1:0] rudder_stick_offset = '0;
	logic signed [RollW-1:0] roll_angle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PulseW-1:0] pulse_zero, pulse_one, pulse_two, pulse_three, pulse_four, pulse_five;
	logic [CntW-1:0] channels_driven;

	servo_output_mixer uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.aileron_cmd(aileron_cmd),
		.elevator_cmd(elevator_cmd),
		.motor_cmd(motor_cmd),
		.yaw_cmd(yaw_cmd),
		.rudder_stick_offset(rudder_stick_offset),
		.roll_angle(roll_angle),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pulse_zero(pulse_zero),
		.pulse_one(pulse_one),
		.pulse_two(pulse_two),
		.pulse_three(pulse_three),
		.pulse_four(pulse_four),
		.pulse_five(pulse_five),
		.channels_driven(channels_driven)
	);

	mixer_setting_t model_cfg;
	pulse_t [NumServo-1:0] held_pulses;
	servo_frame_t pending_frames[$];
	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int configs_loaded = 0;
	int input_stall_cycles = 0;
	logic [7:0] modes_seen = '0;
	bit gaps_on = 1'b0;
	int burst_left = 1;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int stall_style = 0;
	int cycle_count = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic servo_frame_t mix_servo_cmd(input servo_cmd_t c);
		servo_frame_t f;
		longint a, e, m, w, y, roll, q, r, l, gyro, d, x, mx, mn;
		longint v[NumServo];
		longint n[NumServo];
		logic [NumServo-1:0] rev;
		int cnt;
		a = longint'(c.ail);
		e = longint'(c.elev);
		m = longint'(c.motor);
		w = longint'(c.yaw);
		y = longint'(c.rudder);
		roll = longint'(c.roll);
		d = longint'(model_cfg.setup[6:3]);
		rev = model_cfg.setup[12:7];
		for (int i = 0; i < NumServo; i++) begin
			n[i] = longint'(model_cfg.neutral[i]);
			v[i] = longint'(held_pulses[i]);
		end
		q = a / DIFF_DIV;
		if (a > 0) begin
			r = a + q * d;
			l = a - q * d;
		end else begin
			r = a - q * d;
			l = a + q * d;
		end
		gyro = (roll * GYRO_GAIN) / GYRO_SCALE;
		case (model_cfg.setup[2:0])
			MODE_DELTA_PLUS, MODE_DELTA_MINUS: begin
				cnt = CNT_DELTA;
				v[4] = GyroCenter + (rev[4] ? -gyro : gyro);
				if (model_cfg.setup[2:0] == MODE_DELTA_PLUS) begin
					v[0] = (rev[0] ? (r + e) : (-r - e)) + n[0];
					v[1] = (rev[1] ? (l - e) : (-l + e)) + n[1];
				end else begin
					v[0] = (rev[0] ? (r - e) : (-r + e)) + n[0];
					v[1] = (rev[1] ? (l + e) : (-l - e)) + n[1];
				end
				v[3] = (rev[3] ? -m : m) + n[3];
			end
			MODE_QUAD: begin
				cnt = CNT_QUAD;
				v[0] = m + a / QUAD_DIV + w / QUAD_DIV + n[0];
				v[1] = m + e / QUAD_DIV - w / QUAD_DIV + n[1];
				v[2] = m - a / QUAD_DIV + w / QUAD_DIV + n[2];
				v[3] = m - e / QUAD_DIV - w / QUAD_DIV + n[3];
				if (m < QuadIdle) begin
					for (int i = 0; i < 4; i++) v[i] = 0;
				end
			end
			default: begin
				if (model_cfg.setup[2:0] != MODE_FLAPERON) y = 0;
				cnt = CNT_WING;
				v[5] = GyroCenter + (rev[5] ? -gyro : gyro);
				v[0] = (rev[0] ? (-r + y) : (r - y)) + n[0];
				v[1] = (rev[1] ? (l + y) : (-l - y)) + n[1];
				v[2] = (rev[2] ? -e : e) + n[2];
				v[3] = (rev[3] ? -m : m) + n[3];
				v[4] = (rev[4] ? w : -w) + n[4];
			end
		endcase
		for (int i = 0; i < cnt; i++) begin
			mx = longint'(model_cfg.maximum[i]);
			mn = longint'(model_cfg.minimum[i]);
			x = v[i];
			if (x > mx) x = mx;
			if (x < mn) x = mn;
			held_pulses[i] = pulse_t'(x);
		end
		f.pulse = held_pulses;
		f.driven = CntW'(cnt);
		return f;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		servo_frame_t want, got;
		if (!arst_n) begin
			model_cfg.setup = '0;
			for (int i = 0; i < NumServo; i++) begin
				model_cfg.neutral[i] = NEUTRAL_RST;
				model_cfg.minimum[i] = MINIMUM_RST;
				model_cfg.maximum[i] = MAXIMUM_RST;
			end
			held_pulses = '0;
		end else begin
			if (out_valid && !out_stall) begin
				got.pulse = {pulse_five, pulse_four, pulse_three, pulse_two, pulse_one,
					pulse_zero};
				got.driven = channels_driven;
				if (pending_frames.size() == 0) begin
					$display("%0t ns: result with nothing expected, got %h", $time, got);
					errors++;
				end else begin
					want = pending_frames.pop_front();
					for (int i = 0; i < NumServo; i++) begin
						if (got.pulse[i] !== want.pulse[i]) begin
							$display("%0t ns: servo %0d pulse expected %0d, got %0d", $time, i,
								want.pulse[i], got.pulse[i]);
							errors++;
						end
					end
					if (got.driven !== want.driven) begin
						$display("%0t ns: channels_driven expected %0d, got %0d", $time,
							want.driven, got.driven);
						errors++;
					end
				end
				results_seen <= results_seen + 1;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MIXING_SETUP: model_cfg.setup = cfg_wdata[SetupW-1:0];
					REG_NEUTRAL_LOW:  model_cfg.neutral[2:0] = cfg_wdata;
					REG_NEUTRAL_HIGH: model_cfg.neutral[5:3] = cfg_wdata;
					REG_MINIMUM_LOW:  model_cfg.minimum[2:0] = cfg_wdata;
					REG_MINIMUM_HIGH: model_cfg.minimum[5:3] = cfg_wdata;
					REG_MAXIMUM_LOW:  model_cfg.maximum[2:0] = cfg_wdata;
					REG_MAXIMUM_HIGH: model_cfg.maximum[5:3] = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_stall) input_stall_cycles++;
			if (in_valid && !in_stall) begin
				modes_seen[model_cfg.setup[2:0]] = 1'b1;
				pending_frames.push_back(mix_servo_cmd('{ail: aileron_cmd,
					elev: elevator_cmd, motor: motor_cmd, yaw: yaw_cmd,
					rudder: rudder_stick_offset, roll: roll_angle}));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (hold_asked != hold_given) begin
			hold_given = hold_asked;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			if (cycle_count % 64 == 0) stall_style = $urandom_range(0, 3);
			case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= cycle_count[1] & cycle_count[2];
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t ns: no transaction for %0d cycles", $time, quiet_cycles);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	function automatic logic signed [CmdW-1:0] rand_field();
		case ($urandom_range(0, 7))
			0: begin
				case ($urandom_range(0, 3))
					0: return 12'sh800;
					1: return 12'sh7ff;
					2: return 12'sh000;
					default: return 12'shfff;
				endcase
			end
			1: return CmdW'(int'($urandom_range(0, 240)) - 120);
			default: return CmdW'($urandom_range(0, 4095));
		endcase
	endfunction

	function automatic servo_cmd_t rand_cmd(input bit near_idle);
		servo_cmd_t c;
		c.ail = rand_field();
		c.elev = rand_field();
		c.motor = rand_field();
		c.yaw = rand_field();
		c.rudder = rand_field();
		case ($urandom_range(0, 7))
			0: c.roll = 15'sh4000;
			1: c.roll = 15'sh3fff;
			default: c.roll = RollW'($urandom_range(0, 32767));
		endcase
		if (near_idle && $urandom_range(0, 1)) c.motor = CmdW'($urandom_range(QuadIdle - 20,
			QuadIdle + 20));
		return c;
	endfunction

	function automatic servo_cmd_t make_cmd(input int a, input int e, input int m, input int w,
		input int y, input int roll);
		servo_cmd_t c;
		c.ail = CmdW'(a);
		c.elev = CmdW'(e);
		c.motor = CmdW'(m);
		c.yaw = CmdW'(w);
		c.rudder = CmdW'(y);
		c.roll = RollW'(roll);
		return c;
	endfunction

	function automatic mixer_setting_t make_setting(input mix_mode_t mode, input int diff,
		input int rev, input int neutral, input int lo, input int hi);
		mixer_setting_t s;
		s.setup = {NumServo'(rev), DiffW'(diff), mode};
		for (int i = 0; i < NumServo; i++) begin
			s.neutral[i] = pulse_t'(neutral);
			s.minimum[i] = pulse_t'(lo);
			s.maximum[i] = pulse_t'(hi);
		end
		return s;
	endfunction

	function automatic mixer_setting_t rand_setting(input int mode);
		mixer_setting_t s;
		int style;
		style = $urandom_range(0, 9);
		s.setup = SetupW'($urandom_range(0, 8191));
		s.setup[2:0] = ModeW'(mode);
		for (int i = 0; i < NumServo; i++) begin
			case (style)
				0: begin
					s.neutral[i] = pulse_t'($urandom);
					s.minimum[i] = '0;
					s.maximum[i] = '1;
				end
				1: begin
					s.neutral[i] = pulse_t'($urandom);
					s.minimum[i] = pulse_t'($urandom_range(1600, 4095));
					s.maximum[i] = pulse_t'($urandom_range(0, 1400));
				end
				2: begin
					s.neutral[i] = pulse_t'($urandom);
					s.minimum[i] = pulse_t'($urandom);
					s.maximum[i] = pulse_t'($urandom);
				end
				default: begin
					s.neutral[i] = pulse_t'($urandom_range(1200, 1800));
					s.minimum[i] = pulse_t'($urandom_range(800, 1200));
					s.maximum[i] = pulse_t'($urandom_range(1800, 2300));
				end
			endcase
		end
		return s;
	endfunction

	task automatic load_config(input mixer_setting_t s);
		logic [RegW-1:0] vals[7];
		logic [IdxW-1:0] idx[7];
		idx = '{REG_MIXING_SETUP, REG_NEUTRAL_LOW, REG_NEUTRAL_HIGH, REG_MINIMUM_LOW,
			REG_MINIMUM_HIGH, REG_MAXIMUM_LOW, REG_MAXIMUM_HIGH};
		vals = '{RegW'(s.setup), s.neutral[2:0], s.neutral[5:3], s.minimum[2:0],
			s.minimum[5:3], s.maximum[2:0], s.maximum[5:3]};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		configs_loaded++;
	endtask

	task automatic send_cmd(input servo_cmd_t c);
		aileron_cmd <= c.ail;
		elevator_cmd <= c.elev;
		motor_cmd <= c.motor;
		yaw_cmd <= c.yaw;
		rudder_stick_offset <= c.rudder;
		roll_angle <= c.roll;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (results_seen != items_sent) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		gaps_on = 1'b0;
		send_cmd(make_cmd(0, 0, 0, 0, 0, 0));
		send_cmd(make_cmd(2047, 2047, 2047, 2047, 2047, 16383));
		send_cmd(make_cmd(-2048, -2048, -2048, -2048, -2048, -16384));
		send_cmd(make_cmd(9, -9, 500, -500, 300, 1));
		send_cmd(make_cmd(-9, 9, -500, 500, -300, -1));
		send_cmd(make_cmd(10, 100, 0, 0, 0, 4096));
		send_cmd(make_cmd(-10, -100, 0, 0, 0, -4096));
		settle();
	endtask

	task automatic test_mixing_modes();
		for (int md = 0; md < 8; md++) begin
			load_config(make_setting(mix_mode_t'(md), 15, (md % 2) ? 63 : 0, 2048, 0, 4095));
			send_cmd(make_cmd(1234, -567, 890, -321, 456, 5000));
			settle();
		end
	endtask

	task automatic test_quad_idle();
		load_config(make_setting(MODE_QUAD, 7, 21, 1500, 1000, 2000));
		send_cmd(make_cmd(400, -400, QuadIdle - 1, 250, 0, 0));
		send_cmd(make_cmd(400, -400, QuadIdle, 250, 0, 0));
		send_cmd(make_cmd(-2048, 2047, -2048, -2048, 0, 0));
		settle();
	endtask

	task automatic test_inverted_limits();
		load_config(make_setting(MODE_AILERON, 0, 42, 4095, 4095, 0));
		send_cmd(make_cmd(700, 300, -200, 100, 50, 8000));
		settle();
		load_config(make_setting(MODE_FLAPERON, 3, 0, 0, 0, 4095));
		send_cmd(make_cmd(-700, -300, 200, -100, -2048, -8000));
		settle();
	endtask

	task automatic test_backpressure();
		load_config(rand_setting($urandom_range(0, 7)));
		gaps_on = 1'b0;
		hold_asked++;
		for (int i = 0; i < 30; i++) send_cmd(rand_cmd(1'b0));
		settle();
	endtask

	task automatic test_random_traffic();
		int count;
		mixer_setting_t s;
		for (int ph = 0; ph < 12; ph++) begin
			s = rand_setting(ph % 8);
			load_config(s);
			gaps_on = (ph % 3 != 0);
			burst_left = $urandom_range(1, 24);
			count = $urandom_range(38, 46);
			for (int i = 0; i < count; i++) begin
				if (ph == 6 && i == count / 2) settle();
				if (ph == 9 && i == 5) hold_asked++;
				send_cmd(rand_cmd(s.setup[2:0] == MODE_QUAD));
			end
			settle();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_mixing_modes();
		test_quad_idle();
		test_inverted_limits();
		test_backpressure();
		test_random_traffic();
		settle();
		repeat (4) @(posedge clk);
		if (pending_frames.size() != 0) begin
			$display("%0t ns: %0d expected results never arrived", $time, pending_frames.size());
			errors++;
		end
		$display("Checked %0d results for %0d transactions across %0d register settings.",
			results_seen, items_sent, configs_loaded);
		$display("Mode codes seen %b, input held back for %0d cycles, %0d mismatches.",
			modes_seen, input_stall_cycles, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
